>>> rtl/stereo_table_waveshaper_assert.svh
// Assertion macros for the waveshaper.
`ifndef STEREO_TABLE_WAVESHAPER_ASSERT_SVH
`define STEREO_TABLE_WAVESHAPER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define STW_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("waveshaper check failed");

// Next-cycle implication, checked out of reset.
`define STW_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("waveshaper check failed");

`endif

>>> rtl/stw_pkg.sv
`default_nettype none
package stw_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int FRAC_BITS      = SAMPLE_BITS - 1;
    localparam int ADDR_BITS      = 14;
    localparam int TABLE_SIZE_DEF = 1024;
    localparam int NUM_BANKS_DEF  = 16;

    localparam int ENV_BITS = 17;
    localparam int ENV_ONE  = 65536;
    localparam int ENV_RISE = 131;
    localparam int ENV_FALL = 39;
    localparam int MIX_ONE  = 16384;

    localparam int SUM_BITS = SAMPLE_BITS + 2;
    localparam int MUL_A_BITS = 26;
    localparam int MUL_B_BITS = 24;
    localparam int MUL_P_BITS = MUL_A_BITS + MUL_B_BITS;

    localparam int APB_ADDR_BITS = 5;
    localparam int APB_DATA_BITS = 32;

    localparam logic [15:0] RST_INPUT_GAIN  = 16'd16384;
    localparam logic [15:0] RST_OUTPUT_GAIN = 16'd16384;
    localparam logic [14:0] RST_SHAPING_MIX = 15'd16384;

    typedef enum logic [2:0] {
        REG_INPUT_GAIN    = 3'd0,
        REG_OUTPUT_GAIN   = 3'd1,
        REG_SHAPING_MIX   = 3'd2,
        REG_DC_OFFSET     = 3'd3,
        REG_SHAPER_ENABLE = 3'd4,
        REG_BANK_SELECT   = 3'd5,
        REG_SHAPE_LOADED  = 3'd6
    } t_reg_idx;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_WRITE  = 1'b1
    } t_op;

    typedef struct packed {
        logic [15:0]                   input_gain;
        logic [15:0]                   output_gain;
        logic [14:0]                   shaping_mix;
        logic signed [SAMPLE_BITS-1:0] dc_offset;
        logic                          shaper_enable;
        logic [3:0]                    bank_select;
        logic                          shape_loaded;
    } t_cfg;

endpackage
`default_nettype wire

>>> rtl/stereo_table_waveshaper.sv
// Sample word: the next word is taken only once its result is registered for output;
// when shaping, the shared 26x24 multiplier runs ten products in series.
// Table-write word: no result.
// Synchronous active-low reset clears control, envelope and previous sum, sets config to defaults;
// the shape memory is not cleared and must be written before it is read.
`default_nettype none
`include "stereo_table_waveshaper_assert.svh"
module stereo_table_waveshaper #(
    parameter int TABLE_SIZE = stw_pkg::TABLE_SIZE_DEF,
    parameter int NUM_BANKS  = stw_pkg::NUM_BANKS_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    // APB
    input  wire          psel,
    input  wire          penable,
    input  wire          pwrite,
    input  wire  [4:0]   paddr,
    input  wire  [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // input stream
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // left_sample, right_sample, table_address, table_left_word, table_right_word, pad
    input  wire  [111:0] s_axis_tdata,
    // operation
    input  wire  [0:0]   s_axis_tuser,
    // output stream
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // left_out, right_out
    output logic [47:0]  m_axis_tdata
);

    localparam int SB    = stw_pkg::SAMPLE_BITS;
    localparam int FB    = stw_pkg::FRAC_BITS;
    localparam int DEPTH = TABLE_SIZE * NUM_BANKS;
    localparam int AW    = $clog2(DEPTH);
    localparam int EW    = $clog2(TABLE_SIZE);
    localparam int POS_SCALE = TABLE_SIZE / 2 - 1;
    localparam int PB    = stw_pkg::MUL_P_BITS;

    typedef enum logic [16:0] {
        S_IDLE = 17'h00001,
        S_WR   = 17'h00002,
        S_MSUM = 17'h00004,
        S_SUM  = 17'h00008,
        S_MPOS = 17'h00010,
        S_POS  = 17'h00020,
        S_RD1  = 17'h00040,
        S_RD2  = 17'h00080,
        S_MINT = 17'h00100,
        S_AINT = 17'h00200,
        S_MENV = 17'h00400,
        S_AENV = 17'h00800,
        S_MMIX = 17'h01000,
        S_AMIX = 17'h02000,
        S_MOG  = 17'h04000,
        S_AOG  = 17'h08000,
        S_OUT  = 17'h10000
    } t_state;

    t_state r_state, n_state;

    stw_pkg::t_cfg cfg;

    logic signed [SB-1:0] r_left, r_right, r_twl, r_twr;
    logic [13:0]         r_taddr;
    logic signed [stw_pkg::SUM_BITS-1:0] r_sum, n_sum, r_prev;
    logic [stw_pkg::ENV_BITS-1:0] r_env;
    logic [FB-1:0]       r_frac;
    logic [AW-1:0]       r_base;
    logic signed [SB-1:0] r_al, r_ar, r_bl, r_br;
    logic                r_ch;
    logic signed [SB-1:0] r_wet;
    logic signed [SB-1:0] r_res_l, r_res_r;
    logic                r_mvalid;
    logic [47:0]         r_mdata;

    logic signed [stw_pkg::MUL_A_BITS-1:0] mul_a;
    logic signed [stw_pkg::MUL_B_BITS-1:0] mul_b;
    logic signed [PB-1:0]                  prod;

    logic          ram_we;
    logic [AW-1:0] ram_raddr;
    logic [47:0]   ram_rdata;

    logic signed [SB-1:0] a_c, b_c, dry_c;
    logic signed [SB:0]   lr_sum;
    logic signed [26:0]   sum_full;
    logic [SB-1:0]        wrap_off;
    logic [EW-1:0]        entry;
    logic [AW-1:0]        bank_idx, base;
    logic [14:0]          mix_eff;
    logic signed [35:0]   scaled;
    logic signed [SB-1:0] sat;
    logic [stw_pkg::ENV_BITS:0] env_up;
    logic                 out_free;

    stw_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_cfg     (cfg)
    );
    assign pready = 1'b1;

    stw_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    // word holds {right, left}
    stw_ram #(.WIDTH(2 * SB), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(r_taddr)),
        .i_wdata ({r_twr, r_twl}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;
    assign out_free      = !r_mvalid || m_axis_tready;

    assign a_c   = r_ch ? r_ar : r_al;
    assign b_c   = r_ch ? r_br : r_bl;
    assign dry_c = r_ch ? r_right : r_left;

    assign lr_sum   = (SB + 1)'(r_left) + (SB + 1)'(r_right);
    assign sum_full = 27'(prod >>> 15) + 27'(cfg.dc_offset);
    assign n_sum    = sum_full[stw_pkg::SUM_BITS-1:0];
    // adding one half of the range is an MSB flip
    assign wrap_off = {~r_sum[SB-1], r_sum[SB-2:0]};
    assign entry    = prod[FB +: EW];
    assign bank_idx = (32'(cfg.bank_select) >= NUM_BANKS) ? AW'(NUM_BANKS - 1)
                                                           : AW'(cfg.bank_select);
    assign base     = bank_idx * AW'(TABLE_SIZE) + AW'(entry);
    assign mix_eff  = (cfg.shaping_mix > 15'(stw_pkg::MIX_ONE)) ? 15'(stw_pkg::MIX_ONE)
                                                                : cfg.shaping_mix;
    assign scaled   = 36'(prod >>> 14);
    assign sat = (scaled > 36'sd8388607)  ? 24'sh7FFFFF :
                 (scaled < -36'sd8388608) ? 24'sh800000 : scaled[SB-1:0];
    assign env_up   = (stw_pkg::ENV_BITS + 1)'(r_env) + (stw_pkg::ENV_BITS + 1)'(stw_pkg::ENV_RISE);

    assign ram_we    = (r_state == S_WR) && (32'(r_taddr) < DEPTH);
    assign ram_raddr = (r_state == S_RD1) ? r_base + AW'(1) : base;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_MSUM: begin
                mul_a = 26'(lr_sum);
                mul_b = 24'({1'b0, cfg.input_gain});
            end
            S_MPOS: begin
                mul_a = 26'({2'b00, wrap_off});
                mul_b = 24'(POS_SCALE);
            end
            S_MINT: begin
                mul_a = 26'((SB + 1)'(b_c) - (SB + 1)'(a_c));
                mul_b = 24'({1'b0, r_frac});
            end
            S_MENV: begin
                mul_a = 26'(r_wet);
                mul_b = 24'({1'b0, r_env});
            end
            S_MMIX: begin
                mul_a = 26'((SB + 1)'(r_wet) - (SB + 1)'(dry_c));
                mul_b = 24'({1'b0, mix_eff});
            end
            S_MOG: begin
                mul_a = 26'(r_wet);
                mul_b = 24'({1'b0, cfg.output_gain});
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    if (stw_pkg::t_op'(s_axis_tuser[0]) == stw_pkg::OP_WRITE) n_state = S_WR;
                    else if (!cfg.shape_loaded) n_state = S_OUT;
                    else n_state = S_MSUM;
                end
            end
            S_WR:   n_state = S_IDLE;
            S_MSUM: n_state = S_SUM;
            S_SUM:  n_state = cfg.shaper_enable ? S_MPOS : S_OUT;
            S_MPOS: n_state = S_POS;
            S_POS:  n_state = S_RD1;
            S_RD1:  n_state = S_RD2;
            S_RD2:  n_state = S_MINT;
            S_MINT: n_state = S_AINT;
            S_AINT: n_state = S_MENV;
            S_MENV: n_state = S_AENV;
            S_AENV: n_state = S_MMIX;
            S_MMIX: n_state = S_AMIX;
            S_AMIX: n_state = S_MOG;
            S_MOG:  n_state = S_AOG;
            S_AOG:  n_state = r_ch ? S_OUT : S_MINT;
            S_OUT:  n_state = out_free ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_prev   <= '0;
            r_env    <= '0;
            r_mvalid <= 1'b0;
            r_ch     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && out_free) begin
                r_mvalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_mvalid <= 1'b0;
            end
            if (r_state == S_IDLE) begin
                r_ch <= 1'b0;
            end else if (r_state == S_AOG) begin
                r_ch <= 1'b1;
            end
            if (r_state == S_SUM) begin
                if (n_sum == r_prev) begin
                    r_env <= (r_env < stw_pkg::ENV_BITS'(stw_pkg::ENV_FALL)) ? '0 :
                             r_env - stw_pkg::ENV_BITS'(stw_pkg::ENV_FALL);
                end else begin
                    r_env  <= (env_up > (stw_pkg::ENV_BITS + 1)'(stw_pkg::ENV_ONE)) ?
                              stw_pkg::ENV_BITS'(stw_pkg::ENV_ONE) : env_up[stw_pkg::ENV_BITS-1:0];
                    r_prev <= n_sum;
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_left  <= s_axis_tdata[23:0];
                r_right <= s_axis_tdata[47:24];
                r_taddr <= s_axis_tdata[61:48];
                r_twl   <= s_axis_tdata[85:62];
                r_twr   <= s_axis_tdata[109:86];
                r_res_l <= '0;
                r_res_r <= '0;
            end
            S_SUM: begin
                r_sum   <= n_sum;
                r_res_l <= r_left;
                r_res_r <= r_right;
            end
            S_POS: begin
                r_frac <= prod[FB-1:0];
                r_base <= base;
            end
            S_RD1: begin
                r_al <= ram_rdata[SB-1:0];
                r_ar <= ram_rdata[2*SB-1:SB];
            end
            S_RD2: begin
                r_bl <= ram_rdata[SB-1:0];
                r_br <= ram_rdata[2*SB-1:SB];
            end
            S_AINT: r_wet <= SB'((SB + 1)'(a_c) + (SB + 1)'(prod >>> FB));
            S_AENV: r_wet <= SB'(prod >>> 16);
            S_AMIX: r_wet <= SB'((SB + 1)'(dry_c) + (SB + 1)'(prod >>> 14));
            S_AOG: begin
                if (r_ch) r_res_r <= sat;
                else      r_res_l <= sat;
            end
            S_OUT: begin
                if (out_free) r_mdata <= {r_res_r, r_res_l};
            end
            default: ;
        endcase
    end

    `STW_ASSERT_NXT(a_accept_leaves_idle, s_axis_tvalid && s_axis_tready, r_state != S_IDLE)
    `STW_ASSERT_IMP(a_env_in_range, 1'b1, r_env <= stw_pkg::ENV_BITS'(stw_pkg::ENV_ONE))
    `STW_ASSERT_IMP(a_result_from_out, $rose(m_axis_tvalid), $past(r_state) == S_OUT)
    `STW_ASSERT_NXT(a_write_no_result, r_state == S_WR && !m_axis_tvalid, !m_axis_tvalid)

endmodule
`default_nettype wire

>>> rtl/stw_ram.sv
`default_nettype none
module stw_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16384
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> rtl/stw_mul.sv
`default_nettype none
module stw_mul (
    input  wire                                        i_clk,
    input  wire signed [stw_pkg::MUL_A_BITS-1:0]       i_a,
    input  wire signed [stw_pkg::MUL_B_BITS-1:0]       i_b,
    output logic signed [stw_pkg::MUL_P_BITS-1:0]      o_p
);

    logic signed [stw_pkg::MUL_P_BITS-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= stw_pkg::MUL_P_BITS'(i_a) * stw_pkg::MUL_P_BITS'(i_b);
    end

    assign o_p = r_p;

endmodule
`default_nettype wire

>>> rtl/stw_cfg.sv
`default_nettype none
module stw_cfg (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_psel,
    input  wire                                   i_penable,
    input  wire                                   i_pwrite,
    input  wire [stw_pkg::APB_ADDR_BITS-1:0]      i_paddr,
    input  wire [stw_pkg::APB_DATA_BITS-1:0]      i_pwdata,
    output logic [stw_pkg::APB_DATA_BITS-1:0]     o_prdata,
    output stw_pkg::t_cfg                         o_cfg
);

    stw_pkg::t_cfg    r_cfg;
    stw_pkg::t_reg_idx idx;

    assign idx = stw_pkg::t_reg_idx'(i_paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.input_gain    <= stw_pkg::RST_INPUT_GAIN;
            r_cfg.output_gain   <= stw_pkg::RST_OUTPUT_GAIN;
            r_cfg.shaping_mix   <= stw_pkg::RST_SHAPING_MIX;
            r_cfg.dc_offset     <= '0;
            r_cfg.shaper_enable <= 1'b0;
            r_cfg.bank_select   <= '0;
            r_cfg.shape_loaded  <= 1'b0;
        end else if (i_psel && i_penable && i_pwrite) begin
            unique case (idx)
                stw_pkg::REG_INPUT_GAIN:    r_cfg.input_gain    <= i_pwdata[15:0];
                stw_pkg::REG_OUTPUT_GAIN:   r_cfg.output_gain   <= i_pwdata[15:0];
                stw_pkg::REG_SHAPING_MIX:   r_cfg.shaping_mix   <= i_pwdata[14:0];
                stw_pkg::REG_DC_OFFSET:     r_cfg.dc_offset     <= i_pwdata[23:0];
                stw_pkg::REG_SHAPER_ENABLE: r_cfg.shaper_enable <= i_pwdata[0];
                stw_pkg::REG_BANK_SELECT:   r_cfg.bank_select   <= i_pwdata[3:0];
                stw_pkg::REG_SHAPE_LOADED:  r_cfg.shape_loaded  <= i_pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_prdata = '0;
        unique case (idx)
            stw_pkg::REG_INPUT_GAIN:    o_prdata = 32'(r_cfg.input_gain);
            stw_pkg::REG_OUTPUT_GAIN:   o_prdata = 32'(r_cfg.output_gain);
            stw_pkg::REG_SHAPING_MIX:   o_prdata = 32'(r_cfg.shaping_mix);
            stw_pkg::REG_DC_OFFSET:     o_prdata = 32'(unsigned'(r_cfg.dc_offset));
            stw_pkg::REG_SHAPER_ENABLE: o_prdata = 32'(r_cfg.shaper_enable);
            stw_pkg::REG_BANK_SELECT:   o_prdata = 32'(r_cfg.bank_select);
            stw_pkg::REG_SHAPE_LOADED:  o_prdata = 32'(r_cfg.shape_loaded);
            default:                    o_prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire
